// File: rtl/srhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srhc_pkg
// types, command codes and constants shared by the servo ramp controller
// ----------------------------------------------------------------------------
package srhc_pkg;

	localparam int CHANNELS_DEF = 4;

	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_SET_POS    = 3'd1;
	localparam logic [2:0] CMD_SET_PULSE  = 3'd2;
	localparam logic [2:0] CMD_SET_TARGET = 3'd3;
	localparam logic [2:0] CMD_DISABLE    = 3'd4;
	localparam logic [2:0] CMD_QUERY      = 3'd5;

	localparam logic [13:0] TICKS_PER_SEC   = 14'd50;
	localparam logic [10:0] TICKS_PER_TENTH = 11'd5;
	localparam logic [11:0] PULSE_BASE      = 12'd1000;
	localparam logic [9:0]  PULSE_SPAN      = 10'd1000;
	localparam logic [16:0] POS_FULL        = 17'd65535;
	localparam logic [15:0] PULSE_MIN       = 16'd500;
	localparam logic [15:0] PULSE_MAX       = 16'd2500;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  channel;
		logic [15:0] value;
		logic [7:0]  throw_tenths;
		logic [7:0]  hold_secs;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_channel;
		logic [11:0] pulse_level;
		logic        is_moving;
		logic        is_holding;
		logic        is_active;
		logic        completed;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_TICK_INIT = 4'd2,
		OP_APPLY     = 4'd3,
		OP_DIV_STEP  = 4'd4,
		OP_DIV_WB    = 4'd5,
		OP_TICK_STEP = 4'd6,
		OP_MUL       = 4'd7,
		OP_PULSE     = 4'd8,
		OP_EMIT      = 4'd9
	} dp_op_t;

	typedef struct packed {
		logic [2:0] command;
		logic       ch_ok;
		logic       need_div;
		logic       need_map;
		logic       tick_map;
		logic       div_last;
		logic       sel_last;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// File: rtl/servo_ramp_hold_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_ramp_hold_controller
// multi-channel servo position ramp generator with post-move hold timer
// ----------------------------------------------------------------------------
// One command item is taken at a time; cmd_ready is high only while the
// sequencer is idle. Set position, set pulse and disable pass through decode
// and apply; set position then maps its position to a pulse (multiply, pulse
// write). A set target that starts a ramp runs a restoring divider, one
// quotient bit a cycle over 16 bits. A tick walks the channels in order: step,
// multiply and pulse write if ramping, result load, which waits while the
// output register is full. Each result sits there until rsp_ready takes it.
// ----------------------------------------------------------------------------
module servo_ramp_hold_controller #(
	parameter int CHANNELS = srhc_pkg::CHANNELS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  srhc_pkg::in_item_t  cmd_item,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output srhc_pkg::out_item_t rsp_item
);
	import srhc_pkg::*;

	dp_status_t status;
	dp_op_t     op;

	srhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.status    (status),
		.op        (op)
	);

	srhc_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cmd_item  (cmd_item),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	a_move_hold_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_item.is_moving && rsp_item.is_holding))
		else $error("channel reported moving and holding");

	a_flags_need_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_item.is_moving || rsp_item.is_holding) |-> rsp_item.is_active)
		else $error("motion flag set on an inactive channel");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_item.pulse_level == 12'd0)
			|| ((rsp_item.pulse_level >= 12'd500) && (rsp_item.pulse_level <= 12'd2500)))
		else $error("pulse level out of range");

	a_emit_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(cmd_ready))
		else $error("result loaded while sequencer idle");

endmodule
`default_nettype wire

// File: rtl/srhc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srhc_dp
// channel state, step divider, position-to-pulse mapping and result register
// ----------------------------------------------------------------------------
module srhc_dp #(
	parameter int CHANNELS = srhc_pkg::CHANNELS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  srhc_pkg::dp_op_t    op,
	input  srhc_pkg::in_item_t  cmd_item,
	output srhc_pkg::dp_status_t status,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output srhc_pkg::out_item_t rsp_item
);
	import srhc_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [15:0] cur_q     [CHANNELS];
	logic [15:0] tgt_q     [CHANNELS];
	logic [15:0] step_q    [CHANNELS];
	logic [13:0] hold_q    [CHANNELS];
	logic        moving_q  [CHANNELS];
	logic        holding_q [CHANNELS];
	logic        active_q  [CHANNELS];
	logic [11:0] pulse_q   [CHANNELS];

	in_item_t    item_q;
	logic [IDX_W-1:0] sel_q;
	logic        done_q;
	logic [10:0] div_rem_q;
	logic [15:0] div_quo_q;
	logic [10:0] div_dvs_q;
	logic [3:0]  div_cnt_q;
	logic [25:0] prod_q;
	logic        rsp_valid_q;
	out_item_t   rsp_q;

	logic        ch_ok;
	logic        out_free;
	logic [15:0] cur_s;
	logic [15:0] tgt_s;
	logic [15:0] st_s;
	logic [15:0] new_cur;
	logic [15:0] distance;
	logic        need_div;
	logic [11:0] trial;
	logic [9:0]  map_q0;
	logic [16:0] map_sum;
	logic [11:0] map_pulse;
	logic [15:0] clamp_us;

	assign ch_ok    = (4'(item_q.channel) < 4'(CHANNELS));
	assign out_free = !rsp_valid_q || rsp_ready;
	assign cur_s    = cur_q[sel_q];
	assign tgt_s    = tgt_q[sel_q];
	assign st_s     = step_q[sel_q];

	// one step of the ramp toward the target
	always_comb begin
		if (cur_s < tgt_s) begin
			new_cur = ((tgt_s - cur_s) <= st_s) ? tgt_s : cur_s + st_s;
		end else begin
			new_cur = ((cur_s - tgt_s) <= st_s) ? tgt_s : cur_s - st_s;
		end
	end

	assign distance = (cur_s > item_q.value) ? cur_s - item_q.value : item_q.value - cur_s;
	assign need_div = (item_q.command == CMD_SET_TARGET) && (item_q.throw_tenths != 8'd0)
		&& (cur_s != item_q.value);
	assign trial    = {div_rem_q, div_quo_q[15]};

	// divide by 65535: quotient from the high bits, one correction
	assign map_q0    = prod_q[25:16];
	assign map_sum   = {1'b0, prod_q[15:0]} + {7'd0, map_q0};
	assign map_pulse = PULSE_BASE + {2'b00, map_q0} + {11'd0, (map_sum >= POS_FULL)};

	always_comb begin
		clamp_us = item_q.value;
		if (clamp_us < PULSE_MIN) begin
			clamp_us = PULSE_MIN;
		end
		if (clamp_us > PULSE_MAX) begin
			clamp_us = PULSE_MAX;
		end
	end

	always_comb begin
		status.command  = item_q.command;
		status.ch_ok    = ch_ok;
		status.need_div = need_div;
		status.need_map = (item_q.command == CMD_SET_POS)
			|| ((item_q.command == CMD_SET_TARGET) && !need_div);
		status.tick_map = !holding_q[sel_q] && moving_q[sel_q];
		status.div_last = (div_cnt_q == 4'd15);
		status.sel_last = (4'(sel_q) == 4'(CHANNELS - 1));
		status.out_free = out_free;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i]     <= '0;
				tgt_q[i]     <= '0;
				step_q[i]    <= '0;
				hold_q[i]    <= '0;
				moving_q[i]  <= 1'b0;
				holding_q[i] <= 1'b0;
				active_q[i]  <= 1'b0;
				pulse_q[i]   <= '0;
			end
		end else begin
			case (op)
				OP_APPLY: begin
					case (item_q.command)
						CMD_SET_POS: begin
							cur_q[sel_q]     <= item_q.value;
							tgt_q[sel_q]     <= item_q.value;
							moving_q[sel_q]  <= 1'b0;
							holding_q[sel_q] <= 1'b0;
							active_q[sel_q]  <= 1'b1;
						end
						CMD_SET_PULSE: begin
							pulse_q[sel_q]  <= clamp_us[11:0];
							active_q[sel_q] <= 1'b1;
						end
						CMD_SET_TARGET: begin
							tgt_q[sel_q]     <= item_q.value;
							active_q[sel_q]  <= 1'b1;
							hold_q[sel_q]    <= 14'(item_q.hold_secs) * TICKS_PER_SEC;
							holding_q[sel_q] <= 1'b0;
							if (need_div) begin
								moving_q[sel_q] <= 1'b1;
							end else begin
								cur_q[sel_q]    <= item_q.value;
								moving_q[sel_q] <= 1'b0;
								step_q[sel_q]   <= '0;
							end
						end
						CMD_DISABLE: begin
							pulse_q[sel_q]   <= '0;
							moving_q[sel_q]  <= 1'b0;
							holding_q[sel_q] <= 1'b0;
							active_q[sel_q]  <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				OP_DIV_WB: begin
					step_q[sel_q] <= (div_quo_q == 16'd0) ? 16'd1 : div_quo_q;
				end
				OP_TICK_STEP: begin
					if (holding_q[sel_q]) begin
						if (hold_q[sel_q] != 14'd0) begin
							hold_q[sel_q] <= hold_q[sel_q] - 14'd1;
							if (hold_q[sel_q] == 14'd1) begin
								pulse_q[sel_q]   <= '0;
								holding_q[sel_q] <= 1'b0;
								active_q[sel_q]  <= 1'b0;
							end
						end
					end else if (moving_q[sel_q]) begin
						cur_q[sel_q] <= new_cur;
						if (new_cur == tgt_s) begin
							moving_q[sel_q]  <= 1'b0;
							holding_q[sel_q] <= (hold_q[sel_q] != 14'd0);
						end
					end
				end
				OP_PULSE: begin
					pulse_q[sel_q] <= map_pulse;
				end
				default: begin
				end
			endcase
		end
	end

	// item latch, divider and mapping product
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				item_q <= cmd_item;
				sel_q  <= IDX_W'(cmd_item.channel);
			end
			OP_APPLY: begin
				div_quo_q <= distance;
				div_rem_q <= '0;
				div_dvs_q <= 11'(item_q.throw_tenths) * TICKS_PER_TENTH;
				div_cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				if (trial >= {1'b0, div_dvs_q}) begin
					div_rem_q <= 11'(trial - {1'b0, div_dvs_q});
					div_quo_q <= {div_quo_q[14:0], 1'b1};
				end else begin
					div_rem_q <= trial[10:0];
					div_quo_q <= {div_quo_q[14:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			OP_MUL: begin
				prod_q <= cur_q[sel_q] * PULSE_SPAN;
			end
			OP_TICK_INIT: begin
				sel_q <= '0;
			end
			OP_EMIT: begin
				if (item_q.command == CMD_TICK) begin
					sel_q <= sel_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (op == OP_LOAD) begin
			done_q <= 1'b0;
		end else if (op == OP_TICK_STEP) begin
			done_q <= !holding_q[sel_q] && moving_q[sel_q] && (new_cur == tgt_s);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (op == OP_EMIT) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT) begin
			if (item_q.command == CMD_QUERY && !ch_ok) begin
				rsp_q.out_channel <= item_q.channel;
				rsp_q.pulse_level <= '0;
				rsp_q.is_moving   <= 1'b0;
				rsp_q.is_holding  <= 1'b0;
				rsp_q.is_active   <= 1'b0;
				rsp_q.completed   <= 1'b0;
				rsp_q.last        <= 1'b1;
			end else begin
				rsp_q.out_channel <= 2'(sel_q);
				rsp_q.pulse_level <= pulse_q[sel_q];
				rsp_q.is_moving   <= moving_q[sel_q];
				rsp_q.is_holding  <= holding_q[sel_q];
				rsp_q.is_active   <= active_q[sel_q];
				rsp_q.completed   <= done_q && (item_q.command == CMD_TICK);
				rsp_q.last        <= (item_q.command == CMD_QUERY) || status.sel_last;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule
`default_nettype wire

// File: rtl/srhc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srhc_ctrl
// command sequencer driving the datapath one operation per cycle, pausing while the result register is full
// ----------------------------------------------------------------------------
module srhc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_ready,
	input  srhc_pkg::dp_status_t status,
	output srhc_pkg::dp_op_t     op
);
	import srhc_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_APPLY  = 9'b000000100,
		ST_DIV    = 9'b000001000,
		ST_DIV_WB = 9'b000010000,
		ST_TICK   = 9'b000100000,
		ST_MUL    = 9'b001000000,
		ST_PULSE  = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		cmd_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					op        = OP_LOAD;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.command)
					CMD_TICK: begin
						op        = OP_TICK_INIT;
						state_nxt = ST_TICK;
					end
					CMD_QUERY: begin
						state_nxt = ST_EMIT;
					end
					CMD_SET_POS, CMD_SET_PULSE, CMD_SET_TARGET, CMD_DISABLE: begin
						state_nxt = status.ch_ok ? ST_APPLY : ST_IDLE;
					end
					default: begin
						state_nxt = ST_IDLE;
					end
				endcase
			end
			ST_APPLY: begin
				op = OP_APPLY;
				if (status.need_div) begin
					state_nxt = ST_DIV;
				end else if (status.need_map) begin
					state_nxt = ST_MUL;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DIV: begin
				op = OP_DIV_STEP;
				if (status.div_last) begin
					state_nxt = ST_DIV_WB;
				end
			end
			ST_DIV_WB: begin
				op        = OP_DIV_WB;
				state_nxt = ST_IDLE;
			end
			ST_TICK: begin
				op        = OP_TICK_STEP;
				state_nxt = status.tick_map ? ST_MUL : ST_EMIT;
			end
			ST_MUL: begin
				op        = OP_MUL;
				state_nxt = ST_PULSE;
			end
			ST_PULSE: begin
				op        = OP_PULSE;
				state_nxt = (status.command == CMD_TICK) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					op = OP_EMIT;
					if (status.command == CMD_TICK && !status.sel_last) begin
						state_nxt = ST_TICK;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/servo_ramp_hold_controller_test.sv
// ----------------------------------------------------------------------------
// servo_ramp_hold_controller_test
// The servo controller is checked against a behavioral model of its channels.
// A directed list covers the field extremes, every command, clamping, instant
// and ramped moves and the unused command codes. Random episodes follow, with
// hold expiry, sender bursts, receiver stalls and drain pauses.
// ----------------------------------------------------------------------------
module servo_ramp_hold_controller_test;

	import srhc_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 210;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IN_W = $bits(in_item_t);

	class servo_tracker;
		logic [15:0] pos_now [CHANNELS_DEF];
		logic [15:0] pos_goal [CHANNELS_DEF];
		logic [15:0] ramp_step [CHANNELS_DEF];
		logic [13:0] hold_left [CHANNELS_DEF];
		bit ramping [CHANNELS_DEF];
		bit holding [CHANNELS_DEF];
		bit driving [CHANNELS_DEF];
		logic [11:0] pulse_us [CHANNELS_DEF];
		out_item_t awaited_reports[$];
		int mismatch_count;

		function new();
			for (int i = 0; i < CHANNELS_DEF; i++) begin
				pos_now[i] = '0;
				pos_goal[i] = '0;
				ramp_step[i] = '0;
				hold_left[i] = '0;
				ramping[i] = 0;
				holding[i] = 0;
				driving[i] = 0;
				pulse_us[i] = '0;
			end
			mismatch_count = 0;
		endfunction

		function logic [11:0] position_to_pulse(logic [15:0] pos);
			int unsigned scaled;
			scaled = (int'(pos) * int'(PULSE_SPAN)) / int'(POS_FULL);
			return 12'(int'(PULSE_BASE) + scaled);
		endfunction

		function out_item_t status_of(int ch, bit reached, bit is_last);
			out_item_t r;
			r.out_channel = 2'(ch);
			r.pulse_level = pulse_us[ch];
			r.is_moving = ramping[ch];
			r.is_holding = holding[ch];
			r.is_active = driving[ch];
			r.completed = reached;
			r.last = is_last;
			return r;
		endfunction

		function int pending();
			return awaited_reports.size();
		endfunction

		function void note_command(in_item_t it);
			int ch;
			bit reached;
			int unsigned span;
			int unsigned st;
			logic [15:0] us;
			ch = it.channel;
			case (it.command)
				CMD_TICK: begin
					for (int i = 0; i < CHANNELS_DEF; i++) begin
						reached = 0;
						if (holding[i]) begin
							if (hold_left[i] != 0) begin
								hold_left[i] = hold_left[i] - 14'd1;
								if (hold_left[i] == 0) begin
									pulse_us[i] = '0;
									holding[i] = 0;
									driving[i] = 0;
								end
							end
						end else if (ramping[i]) begin
							if (pos_now[i] < pos_goal[i])
								pos_now[i] = (16'(pos_goal[i] - pos_now[i]) <= ramp_step[i]) ?
									pos_goal[i] : 16'(pos_now[i] + ramp_step[i]);
							else
								pos_now[i] = (16'(pos_now[i] - pos_goal[i]) <= ramp_step[i]) ?
									pos_goal[i] : 16'(pos_now[i] - ramp_step[i]);
							pulse_us[i] = position_to_pulse(pos_now[i]);
							if (pos_now[i] == pos_goal[i]) begin
								ramping[i] = 0;
								if (hold_left[i] != 0)
									holding[i] = 1;
								reached = 1;
							end
						end
						awaited_reports.push_back(status_of(i, reached, i == CHANNELS_DEF - 1));
					end
				end
				CMD_SET_POS: begin
					pos_now[ch] = it.value;
					pos_goal[ch] = it.value;
					ramping[ch] = 0;
					holding[ch] = 0;
					driving[ch] = 1;
					pulse_us[ch] = position_to_pulse(it.value);
				end
				CMD_SET_PULSE: begin
					us = it.value;
					if (us < PULSE_MIN)
						us = PULSE_MIN;
					if (us > PULSE_MAX)
						us = PULSE_MAX;
					pulse_us[ch] = 12'(us);
					driving[ch] = 1;
				end
				CMD_SET_TARGET: begin
					pos_goal[ch] = it.value;
					driving[ch] = 1;
					hold_left[ch] = 14'(int'(it.hold_secs) * int'(TICKS_PER_SEC));
					holding[ch] = 0;
					if (pos_now[ch] == it.value || it.throw_tenths == 0) begin
						pos_now[ch] = it.value;
						ramping[ch] = 0;
						ramp_step[ch] = '0;
						pulse_us[ch] = position_to_pulse(it.value);
					end else begin
						span = (pos_now[ch] > it.value) ? int'(pos_now[ch] - it.value) :
							int'(it.value - pos_now[ch]);
						st = span / (int'(it.throw_tenths) * int'(TICKS_PER_TENTH));
						if (st == 0)
							st = 1;
						ramp_step[ch] = 16'(st);
						ramping[ch] = 1;
					end
				end
				CMD_DISABLE: begin
					pulse_us[ch] = '0;
					ramping[ch] = 0;
					holding[ch] = 0;
					driving[ch] = 0;
				end
				CMD_QUERY: begin
					awaited_reports.push_back(status_of(ch, 0, 1));
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatch_count++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_report(out_item_t got);
			out_item_t want;
			if (awaited_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result expected none actual %p", $time, got);
				return;
			end
			want = awaited_reports.pop_front();
			compare_field("out_channel", want.out_channel, got.out_channel);
			compare_field("pulse_level", want.pulse_level, got.pulse_level);
			compare_field("is_moving", want.is_moving, got.is_moving);
			compare_field("is_holding", want.is_holding, got.is_holding);
			compare_field("is_active", want.is_active, got.is_active);
			compare_field("completed", want.completed, got.completed);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_ready;
	in_item_t cmd_item = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	out_item_t rsp_item;

	servo_tracker tracker = new();
	int burst_left = 0;
	int counted_items = 0;
	int idle_cycles = 0;
	int stall_phase = 0;
	int stall_mode = 0;
	logic [7:0] stall_pattern = 8'hff;

	servo_ramp_hold_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_item(cmd_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item)
	);

	always #5 clk = ~clk;

	// receiver stall pattern, in one of four randomly redrawn modes
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 64 == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_pattern <= 8'($urandom);
		end
		case (stall_mode)
			0: rsp_ready <= 1;
			1: rsp_ready <= stall_pattern[stall_phase % 8];
			2: rsp_ready <= ($urandom_range(0, 3) != 0);
			default: rsp_ready <= (stall_phase % 16) >= 8;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_report(rsp_item);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t make_cmd(logic [2:0] cmd, logic [1:0] ch, logic [15:0] val,
		logic [7:0] thr, logic [7:0] hld);
		in_item_t it;
		it.command = cmd;
		it.channel = ch;
		it.value = val;
		it.throw_tenths = thr;
		it.hold_secs = hld;
		return it;
	endfunction

	function automatic logic [15:0] pick_position();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_command();
		in_item_t it;
		int r;
		logic [7:0] thr;
		logic [7:0] hld;
		logic [15:0] us;
		it = in_item_t'(IN_W'({$urandom, $urandom}));
		r = $urandom_range(0, 99);
		if (r < 50) begin
			it.command = CMD_TICK;
		end else if (r < 62) begin
			case ($urandom_range(0, 6))
				0: thr = 8'd0;
				1, 2: thr = 8'($urandom);
				default: thr = 8'($urandom_range(1, 3));
			endcase
			case ($urandom_range(0, 9))
				0, 1: hld = 8'($urandom);
				2, 3, 4: hld = 8'd1;
				default: hld = 8'd0;
			endcase
			it = make_cmd(CMD_SET_TARGET, it.channel, pick_position(), thr, hld);
		end else if (r < 70) begin
			it.command = CMD_SET_POS;
			it.value = pick_position();
		end else if (r < 77) begin
			case ($urandom_range(0, 2))
				0: us = 16'($urandom);
				1: us = 16'($urandom_range(0, 3000));
				default: us = 16'($urandom_range(400, 2600));
			endcase
			it.command = CMD_SET_PULSE;
			it.value = us;
		end else if (r < 82) begin
			it.command = CMD_DISABLE;
		end else if (r < 95) begin
			it.command = CMD_QUERY;
		end else begin
			it.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
		end
		return it;
	endfunction

	// called at a rising edge; returns at the edge that takes the item
	task automatic issue(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1;
		cmd_item <= it;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		tracker.note_command(it);
		if (it.command != CMD_SPARE_LO && it.command != CMD_SPARE_HI)
			counted_items++;
	endtask

	task automatic drain_reports();
		cmd_valid <= 0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	// ramp with a one second hold, ticked long enough for the hold to expire
	task automatic hold_episode();
		logic [1:0] ch;
		ch = 2'($urandom);
		issue(make_cmd(CMD_SET_TARGET, ch, pick_position(), 8'($urandom_range(1, 2)), 8'd1));
		repeat ($urandom_range(72, 80)) begin
			if ($urandom_range(0, 9) == 0)
				issue(make_cmd(CMD_QUERY, ch, 16'($urandom), 8'($urandom), 8'($urandom)));
			else
				issue(make_cmd(CMD_TICK, 2'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom)));
		end
	endtask

	initial begin
		int directed_items;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		issue(make_cmd(CMD_QUERY, 2'd0, 16'h0000, 8'h00, 8'h00));
		issue(make_cmd(CMD_TICK, 2'd3, 16'hffff, 8'hff, 8'hff));
		issue(make_cmd(CMD_SET_POS, 2'd0, 16'h0000, 8'h00, 8'h00));
		issue(make_cmd(CMD_SET_POS, 2'd1, 16'hffff, 8'hff, 8'hff));
		issue(make_cmd(CMD_SET_PULSE, 2'd2, 16'h0000, 8'h00, 8'h00));
		issue(make_cmd(CMD_SET_PULSE, 2'd3, 16'hffff, 8'h00, 8'h00));
		issue(make_cmd(CMD_QUERY, 2'd2, 16'h0000, 8'h00, 8'h00));
		issue(make_cmd(CMD_QUERY, 2'd3, 16'h0000, 8'h00, 8'h00));
		// instant moves: zero throw, and target equal to current position
		issue(make_cmd(CMD_SET_TARGET, 2'd0, 16'hffff, 8'h00, 8'hff));
		issue(make_cmd(CMD_SET_TARGET, 2'd1, 16'hffff, 8'h03, 8'h01));
		// tiny distance over the longest throw gives the minimum step
		issue(make_cmd(CMD_SET_TARGET, 2'd2, 16'd3, 8'hff, 8'h00));
		issue(make_cmd(CMD_SET_TARGET, 2'd3, 16'd40000, 8'h01, 8'h01));
		repeat (6)
			issue(make_cmd(CMD_TICK, 2'd0, 16'h0000, 8'h00, 8'h00));
		// pulse override while holding leaves the flags alone
		issue(make_cmd(CMD_SET_PULSE, 2'd3, 16'd1500, 8'h00, 8'h00));
		issue(make_cmd(CMD_SET_POS, 2'd2, 16'd12345, 8'h00, 8'h00));
		issue(make_cmd(CMD_DISABLE, 2'd1, 16'hffff, 8'hff, 8'hff));
		issue(make_cmd(CMD_SPARE_LO, 2'd0, 16'hffff, 8'hff, 8'hff));
		issue(make_cmd(CMD_SPARE_HI, 2'd3, 16'h0000, 8'h00, 8'h00));
		issue(make_cmd(CMD_QUERY, 2'd1, 16'hffff, 8'hff, 8'hff));
		issue(make_cmd(CMD_SET_TARGET, 2'd0, 16'h0000, 8'h01, 8'h00));
		issue(make_cmd(CMD_TICK, 2'd1, 16'h5555, 8'haa, 8'h55));
		drain_reports();

		directed_items = counted_items;
		hold_episode();
		while (counted_items - directed_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				drain_reports();
			if ($urandom_range(0, 24) == 0)
				hold_episode();
			else
				issue(random_command());
		end
		cmd_valid <= 0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
